/* rtl/lav_pkg.sv */
// Shared constants and helpers for the look-at view matrix block.
package lav_pkg;

  // Default number of fraction bits in the fixed point format.
  localparam int FRAC_BITS_DEF = 16;

  // Width of a camera vector component.
  localparam int VEC_W = 32;

  // Width of an axis component on the result ports.
  localparam int COL_W = 18;

  // Row codes on the result channel.
  localparam logic [1:0] ROW_X = 2'd0;
  localparam logic [1:0] ROW_Y = 2'd1;
  localparam logic [1:0] ROW_Z = 2'd2;

  // Number of divider stages; each stage resolves four quotient bits.
  function automatic int div_stages(input int frac);
    return (frac + 4) / 4;
  endfunction

  // Cycles from a vector entering the normalizer to its unit vector.
  function automatic int norm_latency(input int frac);
    return 15 + div_stages(frac);
  endfunction

endpackage

/* rtl/lav_delay.sv */
// Fixed-length register delay line that keeps side data aligned with a normalizer.
module lav_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d_in,
  output logic [W-1:0] d_out
);

  logic [W-1:0] pipe_r [D];

  // Shift the data one tap per cycle.
  always_ff @(posedge clk) begin
    pipe_r[0] <= d_in;
    for (int k = 1; k < D; k++) begin
      pipe_r[k] <= pipe_r[k-1];
    end
  end

  assign d_out = pipe_r[D-1];

endmodule

/* rtl/lav_norm.sv */
// Pipelined normalizer for a three-component signed vector.
module lav_norm #(
  parameter int IW        = 33,
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic signed [IW-1:0]        in_vec   [3],
  output logic                        out_valid,
  output logic                        out_zero,
  output logic signed [FRAC_BITS+1:0] out_axis [3]
);
  import lav_pkg::*;

  localparam int AW   = FRAC_BITS + 2;
  localparam int PW   = $clog2(IW);
  localparam int MW   = 30;
  localparam int TOPB = MW - 1;
  localparam int SQW  = 2 * MW;
  localparam int SUMW = SQW + 2;
  localparam int RTW  = 32;
  localparam int NBW  = 2 * RTW;
  localparam int RW   = RTW + 3;
  localparam int LW   = 31;
  localparam int NSQ  = 8;
  localparam int NSD  = div_stages(FRAC_BITS);
  localparam int QW   = 4 * NSD;
  localparam int NW   = MW + FRAC_BITS + 1;

  // Stage a: magnitudes and signs.
  logic          va_r;
  logic [IW-1:0] mag_a_r [3];
  logic [2:0]    neg_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      neg_a_r[i] <= in_vec[i][IW-1];
      mag_a_r[i] <= in_vec[i][IW-1] ? IW'(-in_vec[i]) : IW'(in_vec[i]);
    end
  end

  // Stage b: the leading one of the OR of magnitudes is that of the largest one.
  logic          vb_r, zero_b_r;
  logic [IW-1:0] mag_b_r [3];
  logic [2:0]    neg_b_r;
  logic [PW-1:0] pos_b_r;
  logic [IW-1:0] mor;
  logic [PW-1:0] pos;

  always_comb begin
    mor = mag_a_r[0] | mag_a_r[1] | mag_a_r[2];
    pos = '0;
    for (int k = 0; k < IW; k++) begin
      if (mor[k]) pos = PW'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    mag_b_r  <= mag_a_r;
    neg_b_r  <= neg_a_r;
    pos_b_r  <= pos;
    zero_b_r <= (mor == '0);
  end

  // Stage c: common shift that puts the largest magnitude just below 2^30.
  logic          vc_r, zero_c_r;
  logic [MW-1:0] m_c_r [3];
  logic [2:0]    neg_c_r;
  logic [IW-1:0] sh_t;
  logic [MW-1:0] m_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pos_b_r >= PW'(TOPB)) begin
        sh_t = mag_b_r[i] >> (pos_b_r - PW'(TOPB));
      end else begin
        sh_t = mag_b_r[i] << (PW'(TOPB) - pos_b_r);
      end
      m_c[i] = sh_t[MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    m_c_r    <= m_c;
    neg_c_r  <= neg_b_r;
    zero_c_r <= zero_b_r;
  end

  // Stage d: squares.
  logic           vd_r, zero_d_r;
  logic [SQW-1:0] sq_d_r [3];
  logic [MW-1:0]  m_d_r  [3];
  logic [2:0]     neg_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else begin
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq_d_r[i] <= SQW'(m_c_r[i]) * SQW'(m_c_r[i]);
    end
    m_d_r    <= m_c_r;
    neg_d_r  <= neg_c_r;
    zero_d_r <= zero_c_r;
  end

  // Square root pipeline; its first register holds the sum of squares.
  logic           s_v_r    [NSQ+1];
  logic           s_zero_r [NSQ+1];
  logic [2:0]     s_neg_r  [NSQ+1];
  logic [MW-1:0]  s_m_r    [NSQ+1][3];
  logic [RW-1:0]  s_rem_r  [NSQ+1];
  logic [RTW-1:0] s_root_r [NSQ+1];
  logic [NBW-1:0] s_n_r    [NSQ+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r[0] <= 1'b0;
    end else begin
      s_v_r[0] <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    s_zero_r[0] <= zero_d_r;
    s_neg_r[0]  <= neg_d_r;
    s_m_r[0]    <= m_d_r;
    s_rem_r[0]  <= '0;
    s_root_r[0] <= '0;
    s_n_r[0]    <= NBW'(SUMW'(sq_d_r[0]) + SUMW'(sq_d_r[1]) + SUMW'(sq_d_r[2]));
  end

  genvar k;
  for (k = 0; k < NSQ; k++) begin : g_sqrt
    logic [RW-1:0]  rem_t, trial, rem_nxt;
    logic [RTW-1:0] root_nxt;
    logic [NBW-1:0] n_nxt;

    // Four result bits per stage, restoring digit by digit.
    always_comb begin
      rem_nxt  = s_rem_r[k];
      root_nxt = s_root_r[k];
      n_nxt    = s_n_r[k];
      for (int j = 0; j < 4; j++) begin
        rem_t = {rem_nxt[RW-3:0], n_nxt[NBW-1 -: 2]};
        n_nxt = {n_nxt[NBW-3:0], 2'b00};
        trial = RW'({root_nxt, 2'b01});
        if (rem_t >= trial) begin
          rem_nxt  = rem_t - trial;
          root_nxt = {root_nxt[RTW-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_t;
          root_nxt = {root_nxt[RTW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s_v_r[k+1] <= 1'b0;
      end else begin
        s_v_r[k+1] <= s_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      s_zero_r[k+1] <= s_zero_r[k];
      s_neg_r[k+1]  <= s_neg_r[k];
      s_m_r[k+1]    <= s_m_r[k];
      s_rem_r[k+1]  <= rem_nxt;
      s_root_r[k+1] <= root_nxt;
      s_n_r[k+1]    <= n_nxt;
    end
  end

  // Divider pipeline; its first register holds the rounded dividends.
  logic          d_v_r    [NSD+1];
  logic          d_zero_r [NSD+1];
  logic [2:0]    d_neg_r  [NSD+1];
  logic [LW-1:0] d_len_r  [NSD+1];
  logic [LW-1:0] d_rem_r  [NSD+1][3];
  logic [QW-1:0] d_low_r  [NSD+1][3];
  logic [QW-1:0] d_q_r    [NSD+1][3];
  logic [LW-1:0] len_p;
  logic [NW-1:0] num_p, num_hi;
  logic [LW-1:0] rem_p [3];
  logic [QW-1:0] low_p [3];

  always_comb begin
    len_p = s_root_r[NSQ][LW-1:0];
    for (int i = 0; i < 3; i++) begin
      num_p    = {s_m_r[NSQ][i], FRAC_BITS'(0)} + NW'(len_p >> 1);
      num_hi   = num_p >> QW;
      rem_p[i] = num_hi[LW-1:0];
      low_p[i] = num_p[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r[0] <= 1'b0;
    end else begin
      d_v_r[0] <= s_v_r[NSQ];
    end
  end

  always_ff @(posedge clk) begin
    d_zero_r[0] <= s_zero_r[NSQ];
    d_neg_r[0]  <= s_neg_r[NSQ];
    d_len_r[0]  <= len_p;
    d_rem_r[0]  <= rem_p;
    d_low_r[0]  <= low_p;
    for (int i = 0; i < 3; i++) begin
      d_q_r[0][i] <= '0;
    end
  end

  for (k = 0; k < NSD; k++) begin : g_div
    logic [LW-1:0] rem_nxt [3];
    logic [QW-1:0] low_nxt [3];
    logic [QW-1:0] q_nxt   [3];
    logic [LW:0]   r2;

    // Four quotient bits per stage for each component.
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rem_nxt[i] = d_rem_r[k][i];
        low_nxt[i] = d_low_r[k][i];
        q_nxt[i]   = d_q_r[k][i];
        for (int j = 0; j < 4; j++) begin
          r2         = {rem_nxt[i], low_nxt[i][QW-1]};
          low_nxt[i] = {low_nxt[i][QW-2:0], 1'b0};
          if (r2 >= {1'b0, d_len_r[k]}) begin
            r2       = r2 - {1'b0, d_len_r[k]};
            q_nxt[i] = {q_nxt[i][QW-2:0], 1'b1};
          end else begin
            q_nxt[i] = {q_nxt[i][QW-2:0], 1'b0};
          end
          rem_nxt[i] = r2[LW-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d_v_r[k+1] <= 1'b0;
      end else begin
        d_v_r[k+1] <= d_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      d_zero_r[k+1] <= d_zero_r[k];
      d_neg_r[k+1]  <= d_neg_r[k];
      d_len_r[k+1]  <= d_len_r[k];
      d_rem_r[k+1]  <= rem_nxt;
      d_low_r[k+1]  <= low_nxt;
      d_q_r[k+1]    <= q_nxt;
    end
  end

  // Output stage: restore the signs.
  logic                 vo_r, zero_o_r;
  logic signed [AW-1:0] ax_o_r [3];
  logic signed [AW-1:0] qs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs[i] = AW'(d_q_r[NSD][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= d_v_r[NSD];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ax_o_r[i] <= d_neg_r[NSD][i] ? -qs[i] : qs[i];
    end
    zero_o_r <= d_zero_r[NSD];
  end

  assign out_valid = vo_r;
  assign out_zero  = zero_o_r;
  assign out_axis  = ax_o_r;

endmodule

/* rtl/look_at_view_matrix.sv */
// Top level of the look-at view matrix builder: cross products, translations, row output.
// Camera inputs and translations are Q16.16 by default (FRAC_BITS = 16).
// Rows 0, 1 and 2 follow on consecutive cycles; a new camera can be taken while earlier ones are in flight.
// busy holds off new transfers while cnt_r counts down, so that the row output keeps up.
// The three normalizers are fully pipelined; the square root and divider units set latency.
// Reset (rst_n low, synchronous) clears all valid bits and the row sequencer.
module look_at_view_matrix #(
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [lav_pkg::VEC_W-1:0] in_eye_x,
  input  logic signed [lav_pkg::VEC_W-1:0] in_eye_y,
  input  logic signed [lav_pkg::VEC_W-1:0] in_eye_z,
  input  logic signed [lav_pkg::VEC_W-1:0] in_target_x,
  input  logic signed [lav_pkg::VEC_W-1:0] in_target_y,
  input  logic signed [lav_pkg::VEC_W-1:0] in_target_z,
  input  logic signed [lav_pkg::VEC_W-1:0] in_up_x,
  input  logic signed [lav_pkg::VEC_W-1:0] in_up_y,
  input  logic signed [lav_pkg::VEC_W-1:0] in_up_z,
  output logic                             out_valid,
  output logic [1:0]                       out_row_index,
  output logic signed [lav_pkg::COL_W-1:0] out_col0,
  output logic signed [lav_pkg::COL_W-1:0] out_col1,
  output logic signed [lav_pkg::COL_W-1:0] out_col2,
  output logic signed [lav_pkg::VEC_W-1:0] out_col3,
  output logic                             out_degenerate,
  output logic                             out_last_row
);
  import lav_pkg::*;

  localparam int AW  = FRAC_BITS + 2;
  localparam int NL  = norm_latency(FRAC_BITS);
  localparam int P1W = VEC_W + AW;
  localparam int C1W = P1W + 1;
  localparam int P2W = 2 * AW;
  localparam int C2W = P2W + 1;
  localparam int DW  = VEC_W + AW;
  localparam int SW  = DW + 2;
  localparam int EW  = 3 * VEC_W;
  localparam int XW  = 3 * AW;
  localparam logic signed [SW-1:0] SMAX = (SW'(1) <<< (VEC_W - 1)) - SW'(1);
  localparam logic signed [SW-1:0] SMIN = -(SW'(1) <<< (VEC_W - 1));
  localparam logic signed [SW-1:0] RHALF = SW'(1) <<< (FRAC_BITS - 1);

  // Intake: after a transfer, busy stays high until cnt_r counts down to zero.
  logic [1:0] cnt_r;
  logic       accept;

  assign accept = start && !busy;
  assign busy   = (cnt_r != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (accept) begin
      cnt_r <= 2'd2;
    end else if (cnt_r != 2'd0) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // Stage 0: capture the camera.
  logic                    v0_r;
  logic signed [VEC_W-1:0] eye0_r [3];
  logic signed [VEC_W-1:0] tgt0_r [3];
  logic signed [VEC_W-1:0] up0_r  [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    eye0_r <= '{in_eye_x, in_eye_y, in_eye_z};
    tgt0_r <= '{in_target_x, in_target_y, in_target_z};
    up0_r  <= '{in_up_x, in_up_y, in_up_z};
  end

  // Stage 1: view direction eye - target.
  logic                    v1_r;
  logic signed [VEC_W:0]   d1_r   [3];
  logic signed [VEC_W-1:0] eye1_r [3];
  logic signed [VEC_W-1:0] up1_r  [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      d1_r[j] <= (VEC_W+1)'(eye0_r[j]) - (VEC_W+1)'(tgt0_r[j]);
    end
    eye1_r <= eye0_r;
    up1_r  <= up0_r;
  end

  // Normalize the view direction into the z axis.
  logic                 vz, zero0;
  logic signed [AW-1:0] z_ax [3];
  logic [2*EW-1:0]      eu_a;

  lav_norm #(.IW(VEC_W + 1), .FRAC_BITS(FRAC_BITS)) u_norm_z (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v1_r),
    .in_vec   (d1_r),
    .out_valid(vz),
    .out_zero (zero0),
    .out_axis (z_ax)
  );

  lav_delay #(.W(2 * EW), .D(NL)) u_dly_z (
    .clk  (clk),
    .d_in ({eye1_r[0], eye1_r[1], eye1_r[2], up1_r[0], up1_r[1], up1_r[2]}),
    .d_out(eu_a)
  );

  // Stage 2: products for cross(up, z).
  logic                    v2_r, f2_r;
  logic signed [P1W-1:0]   p2_r [6];
  logic signed [VEC_W-1:0] eye2_r [3];
  logic signed [AW-1:0]    z2_r [3];
  logic signed [VEC_W-1:0] up_a [3];
  logic signed [VEC_W-1:0] eye_a [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      eye_a[j] = eu_a[2*EW-1-j*VEC_W -: VEC_W];
      up_a[j]  = eu_a[EW-1-j*VEC_W -: VEC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= vz;
    end
  end

  always_ff @(posedge clk) begin
    p2_r[0] <= P1W'(up_a[1]) * P1W'(z_ax[2]);
    p2_r[1] <= P1W'(up_a[2]) * P1W'(z_ax[1]);
    p2_r[2] <= P1W'(up_a[2]) * P1W'(z_ax[0]);
    p2_r[3] <= P1W'(up_a[0]) * P1W'(z_ax[2]);
    p2_r[4] <= P1W'(up_a[0]) * P1W'(z_ax[1]);
    p2_r[5] <= P1W'(up_a[1]) * P1W'(z_ax[0]);
    eye2_r  <= eye_a;
    z2_r    <= z_ax;
    f2_r    <= zero0;
  end

  // Stage 3: differences for cross(up, z).
  logic                    v3_r, f3_r;
  logic signed [C1W-1:0]   c3_r [3];
  logic signed [VEC_W-1:0] eye3_r [3];
  logic signed [AW-1:0]    z3_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      c3_r[j] <= C1W'(p2_r[2*j]) - C1W'(p2_r[2*j+1]);
    end
    eye3_r <= eye2_r;
    z3_r   <= z2_r;
    f3_r   <= f2_r;
  end

  // Normalize cross(up, z) into the x axis.
  logic                 vx, zero1;
  logic signed [AW-1:0] x_ax [3];
  logic [EW+XW:0]       ezf_b;

  lav_norm #(.IW(C1W), .FRAC_BITS(FRAC_BITS)) u_norm_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v3_r),
    .in_vec   (c3_r),
    .out_valid(vx),
    .out_zero (zero1),
    .out_axis (x_ax)
  );

  lav_delay #(.W(EW + XW + 1), .D(NL)) u_dly_x (
    .clk  (clk),
    .d_in ({eye3_r[0], eye3_r[1], eye3_r[2], z3_r[0], z3_r[1], z3_r[2], f3_r}),
    .d_out(ezf_b)
  );

  // Stage 4: products for cross(z, x).
  logic                    v4_r, f4_r;
  logic signed [P2W-1:0]   p4_r [6];
  logic signed [VEC_W-1:0] eye4_r [3];
  logic signed [AW-1:0]    z4_r [3];
  logic signed [AW-1:0]    x4_r [3];
  logic signed [VEC_W-1:0] eye_b [3];
  logic signed [AW-1:0]    z_b [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      eye_b[j] = ezf_b[EW+XW-j*VEC_W -: VEC_W];
      z_b[j]   = ezf_b[XW-j*AW -: AW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= vx;
    end
  end

  always_ff @(posedge clk) begin
    p4_r[0] <= P2W'(z_b[1]) * P2W'(x_ax[2]);
    p4_r[1] <= P2W'(z_b[2]) * P2W'(x_ax[1]);
    p4_r[2] <= P2W'(z_b[2]) * P2W'(x_ax[0]);
    p4_r[3] <= P2W'(z_b[0]) * P2W'(x_ax[2]);
    p4_r[4] <= P2W'(z_b[0]) * P2W'(x_ax[1]);
    p4_r[5] <= P2W'(z_b[1]) * P2W'(x_ax[0]);
    eye4_r  <= eye_b;
    z4_r    <= z_b;
    x4_r    <= x_ax;
    f4_r    <= ezf_b[0] | zero1;
  end

  // Stage 5: differences for cross(z, x).
  logic                    v5_r, f5_r;
  logic signed [C2W-1:0]   c5_r [3];
  logic signed [VEC_W-1:0] eye5_r [3];
  logic signed [AW-1:0]    z5_r [3];
  logic signed [AW-1:0]    x5_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      c5_r[j] <= C2W'(p4_r[2*j]) - C2W'(p4_r[2*j+1]);
    end
    eye5_r <= eye4_r;
    z5_r   <= z4_r;
    x5_r   <= x4_r;
    f5_r   <= f4_r;
  end

  // Normalize cross(z, x) into the y axis.
  logic                  vy, zero2;
  logic signed [AW-1:0]  y_ax [3];
  logic [EW+2*XW:0]      ezxf_c;

  lav_norm #(.IW(C2W), .FRAC_BITS(FRAC_BITS)) u_norm_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v5_r),
    .in_vec   (c5_r),
    .out_valid(vy),
    .out_zero (zero2),
    .out_axis (y_ax)
  );

  lav_delay #(.W(EW + 2 * XW + 1), .D(NL)) u_dly_y (
    .clk  (clk),
    .d_in ({eye5_r[0], eye5_r[1], eye5_r[2], z5_r[0], z5_r[1], z5_r[2],
            x5_r[0], x5_r[1], x5_r[2], f5_r}),
    .d_out(ezxf_c)
  );

  // Stage 6: dot product terms, rows x, y, z.
  logic                    v6_r, f6_r;
  logic signed [DW-1:0]    p6_r [3][3];
  logic signed [AW-1:0]    ax6_r [3][3];
  logic signed [VEC_W-1:0] eye_c [3];
  logic signed [AW-1:0]    ax_c [3][3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      eye_c[j]   = ezxf_c[EW+2*XW-j*VEC_W -: VEC_W];
      ax_c[2][j] = ezxf_c[2*XW-j*AW -: AW];
      ax_c[0][j] = ezxf_c[XW-j*AW -: AW];
      ax_c[1][j] = y_ax[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= vy;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < 3; j++) begin
        p6_r[r][j] <= DW'(ax_c[r][j]) * DW'(eye_c[j]);
      end
    end
    ax6_r <= ax_c;
    f6_r  <= ezxf_c[0] | zero2;
  end

  // Stage 7: negated sum plus the rounding half.
  logic                 v7_r, f7_r;
  logic signed [SW-1:0] t7_r [3];
  logic signed [AW-1:0] ax7_r [3][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      t7_r[r] <= RHALF - (SW'(p6_r[r][0]) + SW'(p6_r[r][1]) + SW'(p6_r[r][2]));
    end
    ax7_r <= ax6_r;
    f7_r  <= f6_r;
  end

  // Stage 8: drop the fraction (floor) and saturate.
  logic                    v8_r, f8_r;
  logic signed [VEC_W-1:0] tr8_r [3];
  logic signed [AW-1:0]    ax8_r [3][3];
  logic signed [SW-1:0]    sh7 [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sh7[r] = t7_r[r] >>> FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else begin
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      if (sh7[r] > SMAX) begin
        tr8_r[r] <= VEC_W'(SMAX);
      end else if (sh7[r] < SMIN) begin
        tr8_r[r] <= VEC_W'(SMIN);
      end else begin
        tr8_r[r] <= VEC_W'(sh7[r]);
      end
    end
    ax8_r <= ax7_r;
    f8_r  <= f7_r;
  end

  // Row sequencer: holds one matrix and sends its rows x, y and z on consecutive cycles.
  logic                    act_r;
  logic [1:0]              row_r;
  logic                    deg_h_r;
  logic signed [AW-1:0]    ax_h_r [3][3];
  logic signed [VEC_W-1:0] tr_h_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      row_r <= ROW_X;
    end else if (v8_r) begin
      act_r <= 1'b1;
      row_r <= ROW_X;
    end else if (act_r) begin
      act_r <= (row_r != ROW_Z);
      row_r <= (row_r == ROW_Z) ? ROW_X : row_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (v8_r) begin
      ax_h_r  <= ax8_r;
      tr_h_r  <= tr8_r;
      deg_h_r <= f8_r;
    end
  end

  // Select the current row; a degenerate matrix reads as zeros.
  logic signed [AW-1:0]    sel_ax [3];
  logic signed [VEC_W-1:0] sel_tr;

  always_comb begin
    unique case (row_r)
      ROW_X: begin
        sel_ax = ax_h_r[0];
        sel_tr = tr_h_r[0];
      end
      ROW_Y: begin
        sel_ax = ax_h_r[1];
        sel_tr = tr_h_r[1];
      end
      ROW_Z: begin
        sel_ax = ax_h_r[2];
        sel_tr = tr_h_r[2];
      end
      default: begin
        sel_ax = ax_h_r[0];
        sel_tr = tr_h_r[0];
      end
    endcase
  end

  assign out_valid      = act_r;
  assign out_row_index  = row_r;
  assign out_col0       = deg_h_r ? '0 : COL_W'(sel_ax[0]);
  assign out_col1       = deg_h_r ? '0 : COL_W'(sel_ax[1]);
  assign out_col2       = deg_h_r ? '0 : COL_W'(sel_ax[2]);
  assign out_col3       = deg_h_r ? '0 : sel_tr;
  assign out_degenerate = deg_h_r;
  assign out_last_row   = act_r && (row_r == ROW_Z);

  // A transfer must be followed by busy, which holds off the next one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy ##1 busy))
    else $error("busy did not cover the two cycles after a transfer");

  // Rows of one matrix come out back to back in order.
  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_row_index == ROW_X) |=> (out_valid && out_row_index == ROW_Y))
    else $error("row y did not follow row x");

  a_row_order_z: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_row_index == ROW_Y) |=> (out_valid && out_row_index == ROW_Z))
    else $error("row z did not follow row y");

  // A new matrix never lands in the hold registers in the middle of a run.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    v8_r |-> (!act_r || row_r == ROW_Z))
    else $error("matrix arrived while rows were still being sent");

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the look-at view matrix builder.
module tb_top;
  import lav_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int Q = 1 << FB;
  localparam int LIMIT = 400000;

  typedef struct {
    logic signed [VEC_W-1:0] v[9];
  } camera_t;

  typedef struct {
    logic [1:0]              row;
    logic signed [COL_W-1:0] c0, c1, c2;
    logic signed [VEC_W-1:0] c3;
    logic                    degen, last;
  } view_row_t;

  typedef struct {
    camera_t cam;
    bit      degen_known;
  } stim_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [VEC_W-1:0] in_f[9];
  logic out_valid;
  logic [1:0] out_row_index;
  logic signed [COL_W-1:0] out_col0, out_col1, out_col2;
  logic signed [VEC_W-1:0] out_col3;
  logic out_degenerate, out_last_row;

  view_row_t expected_rows[$];
  int mismatches = 0;
  int cycles = 0;
  stim_t table_rows[$];

  always #5 clk = ~clk;

  look_at_view_matrix dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_eye_x(in_f[0]), .in_eye_y(in_f[1]), .in_eye_z(in_f[2]),
    .in_target_x(in_f[3]), .in_target_y(in_f[4]), .in_target_z(in_f[5]),
    .in_up_x(in_f[6]), .in_up_y(in_f[7]), .in_up_z(in_f[8]),
    .out_valid(out_valid), .out_row_index(out_row_index),
    .out_col0(out_col0), .out_col1(out_col1), .out_col2(out_col2),
    .out_col3(out_col3), .out_degenerate(out_degenerate), .out_last_row(out_last_row)
  );

  // Integer square root, bit by bit.
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Scale to a common exponent, then divide each magnitude by the length.
  function automatic bit unit_vector(input longint v[3], output longint u[3]);
    longint unsigned m[3];
    longint unsigned big, len, sq, qt;
    int rs, ls;
    big = 0; sq = 0; rs = 0; ls = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (v[i] < 0) ? longint'(-v[i]) : v[i];
      if (m[i] > big) big = m[i];
    end
    if (big == 0) return 1'b0;
    while (big >= (64'd1 << 30)) begin big = big >> 1; rs++; end
    while (big < (64'd1 << 29)) begin big = big << 1; ls++; end
    for (int i = 0; i < 3; i++) begin
      m[i] = (m[i] >> rs) << ls;
      sq += m[i] * m[i];
    end
    len = int_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      qt = ((m[i] << FB) + (len >> 1)) / len;
      u[i] = (v[i] < 0) ? -longint'(qt) : longint'(qt);
    end
    return 1'b1;
  endfunction

  function automatic void cross3(input longint a[3], input longint b[3], output longint c[3]);
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  // Negated dot product, rounded half up to the fixed point grid, then saturated.
  function automatic logic signed [VEC_W-1:0] translation(input longint a[3],
                                                          input longint e[3]);
    longint t;
    t = -(a[0] * e[0] + a[1] * e[1] + a[2] * e[2]) + (longint'(1) << (FB - 1));
    t = t >>> FB;
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    if (t < -64'sd2147483648) t = -64'sd2147483648;
    return t[VEC_W-1:0];
  endfunction

  // Expected three rows of the view matrix for one camera.
  task automatic push_view_rows(input camera_t cam);
    longint eye[3], d[3], up[3], c[3], ax[3][3];
    bit ok;
    view_row_t r;
    for (int j = 0; j < 3; j++) begin
      eye[j] = cam.v[j];
      d[j] = longint'(cam.v[j]) - longint'(cam.v[3+j]);
      up[j] = cam.v[6+j];
    end
    ok = unit_vector(d, ax[2]);
    if (ok) begin
      cross3(up, ax[2], c);
      ok = unit_vector(c, ax[0]);
    end
    if (ok) begin
      cross3(ax[2], ax[0], c);
      ok = unit_vector(c, ax[1]);
    end
    for (int i = 0; i < 3; i++) begin
      r.row = i[1:0];
      r.last = (i == 2);
      r.degen = !ok;
      r.c0 = ok ? ax[i][0][COL_W-1:0] : '0;
      r.c1 = ok ? ax[i][1][COL_W-1:0] : '0;
      r.c2 = ok ? ax[i][2][COL_W-1:0] : '0;
      r.c3 = ok ? translation(ax[i], eye) : '0;
      expected_rows.push_back(r);
    end
  endtask

  // Degenerate rows are all zero apart from row index, last flag and degenerate flag.
  task automatic push_degenerate_rows();
    view_row_t r;
    for (int i = 0; i < 3; i++) begin
      r.row = i[1:0]; r.c0 = '0; r.c1 = '0; r.c2 = '0; r.c3 = '0;
      r.degen = 1'b1; r.last = (i == 2);
      expected_rows.push_back(r);
    end
  endtask

  function automatic camera_t mk(input int ex, ey, ez, tx, ty, tz, ux, uy, uz);
    camera_t c;
    c.v[0] = ex; c.v[1] = ey; c.v[2] = ez;
    c.v[3] = tx; c.v[4] = ty; c.v[5] = tz;
    c.v[6] = ux; c.v[7] = uy; c.v[8] = uz;
    return c;
  endfunction

  function automatic logic signed [VEC_W-1:0] rnd_small();
    return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
  endfunction

  // Random camera: mostly well formed, some full range, some degenerate.
  function automatic camera_t random_camera();
    camera_t c;
    int mode, ax;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) c.v[i] = (mode < 3) ? $urandom : rnd_small();
    if (mode == 8) begin
      for (int i = 0; i < 3; i++) c.v[3+i] = c.v[i];
    end else if (mode == 9) begin
      // Up along the view axis, which is along one coordinate axis.
      ax = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++) begin
        c.v[3+i] = (i == ax) ? c.v[i] - ($urandom_range(1, 1000) * Q) : c.v[i];
        c.v[6+i] = (i == ax) ? -$signed($urandom_range(1, 1 << 20)) : 0;
      end
    end
    return c;
  endfunction

  // Compare every result transfer with the oldest expected row.
  always @(posedge clk) begin
    view_row_t e;
    if (rst_n && out_valid) begin
      if (expected_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected row %0d", out_row_index);
      end else begin
        e = expected_rows.pop_front();
        if (e.row !== out_row_index || e.c0 !== out_col0 || e.c1 !== out_col1 ||
            e.c2 !== out_col2 || e.c3 !== out_col3 || e.degen !== out_degenerate ||
            e.last !== out_last_row) begin
          mismatches++;
          if (mismatches <= 10)
            $display("row mismatch: exp %0d %0d %0d %0d %0d d%0b l%0b got %0d %0d %0d %0d %0d d%0b l%0b",
                     e.row, e.c0, e.c1, e.c2, e.c3, e.degen, e.last, out_row_index,
                     out_col0, out_col1, out_col2, out_col3, out_degenerate, out_last_row);
        end
      end
    end
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Present one camera and hold it until the transfer.
  task automatic send_camera(input camera_t cam, input bit degen_known, input bit allow_idle);
    int gap;
    start <= 1'b1;
    for (int i = 0; i < 9; i++) in_f[i] <= cam.v[i];
    do @(posedge clk); while (busy);
    if (degen_known) push_degenerate_rows();
    else push_view_rows(cam);
    if (allow_idle && $urandom_range(0, 99) < 36) begin
      start <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    camera_t cam;
    stim_t s;
    int n;
    rst_n <= 1'b0;
    start <= 1'b0;
    for (int i = 0; i < 9; i++) in_f[i] <= '0;

    // Directed cameras; degenerate ones carry their known result.
    s.degen_known = 1'b0;
    s.cam = mk(0, 0, Q, 0, 0, 0, 0, Q, 0); table_rows.push_back(s);
    s.cam = mk(Q, 2*Q, 3*Q, -Q, 5*Q, 0, 0, 0, Q); table_rows.push_back(s);
    s.cam = mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
               32'h80000000, 32'h7fffffff, 32'h80000000, 0); table_rows.push_back(s);
    s.cam = mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
               32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000); table_rows.push_back(s);
    s.cam = mk(32'h7fffffff, 0, 0, 32'h80000000, 0, 0, 0, 32'h7fffffff, 0);
    table_rows.push_back(s);
    s.cam = mk(1, 0, 0, 0, 0, 0, 0, 1, 0); table_rows.push_back(s);
    s.cam = mk(-1, -1, -1, 1, 1, 1, -1, 1, -1); table_rows.push_back(s);
    s.cam = mk(32'hffffffff, 32'h55555555, 32'haaaaaaaa, 32'h00000001, 32'h12345678,
               32'hedcba987, 32'hffffffff, 32'hffffffff, 32'hffffffff); table_rows.push_back(s);
    s.degen_known = 1'b1;
    // Eye on the target.
    s.cam = mk(5*Q, -3*Q, Q, 5*Q, -3*Q, Q, 0, Q, 0); table_rows.push_back(s);
    s.cam = mk(0, 0, 0, 0, 0, 0, 0, 0, 0); table_rows.push_back(s);
    // Up parallel to the view direction.
    s.cam = mk(0, 0, 4*Q, 0, 0, 0, 0, 0, Q); table_rows.push_back(s);
    s.cam = mk(0, 9*Q, 0, 0, 0, 0, 0, -3, 0); table_rows.push_back(s);
    // Zero up vector.
    s.cam = mk(Q, Q, Q, 0, 0, 0, 0, 0, 0); table_rows.push_back(s);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (table_rows[i]) send_camera(table_rows[i].cam, table_rows[i].degen_known, 1'b1);

    n = 0;
    repeat (150) begin
      cam = random_camera();
      // Long stretch without gaps in the middle of the run.
      send_camera(cam, 1'b0, !(n >= 60 && n < 100));
      n++;
      // Let the pipeline drain completely once.
      if (n == 40) begin
        start <= 1'b0;
        while (expected_rows.size() != 0) @(posedge clk);
      end
    end
    start <= 1'b0;

    while (expected_rows.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* filelist.f */
rtl/lav_pkg.sv
rtl/lav_delay.sv
rtl/lav_norm.sv
rtl/look_at_view_matrix.sv
test/tb_top.sv
